[hw/rtl/sasa_pkg.sv]
// Shared types and defaults for the shift-and-add slice accumulator.
// Used by the front, queue, back and top modules under hw/rtl; depends on nothing else.
`default_nettype none

package sasa_pkg;

    localparam int WIDTH_DEF   = 64;
    localparam int HEIGHT_DEF  = 64;
    localparam int DEPTH_DEF   = 16;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_ACC   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_ACC,
        B_DRAIN,
        B_READ
    } t_back_state;

endpackage

`default_nettype wire

[hw/rtl/sasa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the image store and the voxel store.
`default_nettype none

module sasa_ram #(
    parameter int              DATA_W    = 8,
    parameter int              ADDR_W    = 12,
    parameter longint unsigned NUM_WORDS = 4096
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [NUM_WORDS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/sasa_front.sv]
// Front end: decodes a command, clamps the shifts, checks ranges and forms
// the store addresses. Depends on sasa_pkg.
`default_nettype none

module sasa_front #(
    parameter  int              WIDTH     = sasa_pkg::WIDTH_DEF,
    parameter  int              HEIGHT    = sasa_pkg::HEIGHT_DEF,
    parameter  int              DEPTH     = sasa_pkg::DEPTH_DEF,
    localparam int              PLANE     = WIDTH * HEIGHT,
    localparam longint unsigned VOX_WORDS = longint'(DEPTH) * longint'(PLANE),
    localparam int              XW        = $clog2(WIDTH),
    localparam int              YW        = $clog2(HEIGHT),
    localparam int              PW        = $clog2(PLANE),
    localparam int              VW        = $clog2(VOX_WORDS),
    localparam int              ENTRY_W   = 2 + 1 + 8 + XW + YW + PW + PW + VW
) (
    input  wire logic              i_accept,
    input  wire logic [1:0]        i_command,
    input  wire logic [5:0]        i_row,
    input  wire logic [5:0]        i_col,
    input  wire logic [3:0]        i_slice,
    input  wire logic [7:0]        i_pixel,
    input  wire logic signed [7:0] i_shift_x,
    input  wire logic signed [7:0] i_shift_y,
    output logic                   o_push,
    output logic [ENTRY_W-1:0]     o_entry
);

    sasa_pkg::t_cmd  cmd;
    logic            pos_ok;
    logic            slice_ok;
    logic            act;
    logic [XW-1:0]   xs;
    logic [YW-1:0]   ys;
    logic [PW-1:0]   pos;
    logic [PW-1:0]   off;
    logic [VW-1:0]   vaddr;

    always_comb begin
        cmd      = sasa_pkg::t_cmd'(i_command);
        pos_ok   = (32'(i_row) < HEIGHT) && (32'(i_col) < WIDTH);
        slice_ok = 32'(i_slice) < DEPTH;

        // Negative shifts clamp to zero, large ones to the last index.
        if (i_shift_x[7]) begin
            xs = '0;
        end else if (32'(i_shift_x[6:0]) > WIDTH - 1) begin
            xs = XW'(WIDTH - 1);
        end else begin
            xs = XW'(i_shift_x[6:0]);
        end
        if (i_shift_y[7]) begin
            ys = '0;
        end else if (32'(i_shift_y[6:0]) > HEIGHT - 1) begin
            ys = YW'(HEIGHT - 1);
        end else begin
            ys = YW'(i_shift_y[6:0]);
        end

        pos = PW'(32'(i_row) * WIDTH + 32'(i_col));
        // The shifted source of a pixel sits a fixed distance back in the image.
        off = PW'(32'(ys) * WIDTH + 32'(xs));

        case (cmd)
            sasa_pkg::CMD_LOAD: begin
                act   = pos_ok;
                vaddr = '0;
            end
            sasa_pkg::CMD_ACC: begin
                act   = slice_ok;
                vaddr = VW'(64'(i_slice) * 64'(PLANE));
            end
            sasa_pkg::CMD_READ: begin
                act   = pos_ok && slice_ok;
                vaddr = VW'(64'(i_slice) * 64'(PLANE) + 64'(pos));
            end
            default: begin
                act   = 1'b0;
                vaddr = '0;
            end
        endcase

        o_push  = i_accept;
        o_entry = {i_command, act, i_pixel, xs, ys, pos, off, vaddr};
    end

endmodule

`default_nettype wire

[hw/rtl/sasa_queue.sv]
// Short command queue between the front end and the back end.
// Depends on sasa_pkg for its depth.
`default_nettype none

module sasa_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    input  wire logic              i_pop,
    output logic      [DATA_W-1:0] o_data,
    output logic                   o_empty,
    output logic                   o_full
);

    logic [DATA_W-1:0]             r_mem [sasa_pkg::QUEUE_DEPTH];
    logic [sasa_pkg::QUEUE_AW-1:0] r_wptr;
    logic [sasa_pkg::QUEUE_AW-1:0] r_rptr;
    logic [sasa_pkg::QUEUE_AW:0]   r_count;
    logic [sasa_pkg::QUEUE_AW-1:0] n_wptr;
    logic [sasa_pkg::QUEUE_AW-1:0] n_rptr;
    logic [sasa_pkg::QUEUE_AW:0]   n_count;
    logic                          do_push;
    logic                          do_pop;

    always_comb begin
        o_empty = r_count == '0;
        o_full  = r_count == (sasa_pkg::QUEUE_AW + 1)'(sasa_pkg::QUEUE_DEPTH);
        o_data  = r_mem[r_rptr];
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        n_wptr  = do_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = do_pop ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count + (sasa_pkg::QUEUE_AW + 1)'(do_push)
                          - (sasa_pkg::QUEUE_AW + 1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/sasa_back.sv]
// Back end: clears the voxel store, carries out load, accumulate and read
// transactions against the two RAMs and drives the result register.
// Depends on sasa_pkg and sasa_ram.
`default_nettype none

module sasa_back #(
    parameter  int              WIDTH     = sasa_pkg::WIDTH_DEF,
    parameter  int              HEIGHT    = sasa_pkg::HEIGHT_DEF,
    parameter  int              DEPTH     = sasa_pkg::DEPTH_DEF,
    localparam int              PLANE     = WIDTH * HEIGHT,
    localparam longint unsigned VOX_WORDS = longint'(DEPTH) * longint'(PLANE),
    localparam int              XW        = $clog2(WIDTH),
    localparam int              YW        = $clog2(HEIGHT),
    localparam int              PW        = $clog2(PLANE),
    localparam int              VW        = $clog2(VOX_WORDS),
    localparam int              ENTRY_W   = 2 + 1 + 8 + XW + YW + PW + PW + VW
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [ENTRY_W-1:0] i_entry,
    input  wire logic               i_empty,
    output logic                    o_pop,
    output logic                    o_clearing,
    output logic                    o_done,
    output logic [31:0]             o_voxel_value,
    output logic [1:0]              o_done_command
);

    // Head of the queue.
    logic [1:0]     h_cmd_bits;
    sasa_pkg::t_cmd h_cmd;
    logic           h_act;
    logic [7:0]     h_pixel;
    logic [XW-1:0]  h_xs;
    logic [YW-1:0]  h_ys;
    logic [PW-1:0]  h_pos;
    logic [PW-1:0]  h_off;
    logic [VW-1:0]  h_vaddr;

    sasa_pkg::t_back_state r_state, n_state;
    logic [YW-1:0]  r_r, n_r;
    logic [XW-1:0]  r_c, n_c;
    logic [PW-1:0]  r_pos, n_pos;
    logic [PW-1:0]  r_off, n_off;
    logic [XW-1:0]  r_xs, n_xs;
    logic [YW-1:0]  r_ys, n_ys;
    logic [VW-1:0]  r_vaddr, n_vaddr;
    logic           r_wr_vld, n_wr_vld;
    logic [VW-1:0]  r_wr_addr, n_wr_addr;
    logic [VW-1:0]  r_clr, n_clr;
    logic           r_out_vld, n_out_vld;
    logic [31:0]    r_voxel, n_voxel;
    sasa_pkg::t_cmd r_done_cmd, n_done_cmd;

    logic           in_region;
    logic [32:0]    sum;
    logic [31:0]    sat_sum;
    logic           img_we;
    logic           img_re;
    logic [PW-1:0]  img_raddr;
    logic [7:0]     img_rdata;
    logic           vox_we;
    logic [VW-1:0]  vox_waddr;
    logic [31:0]    vox_wdata;
    logic           vox_re;
    logic [VW-1:0]  vox_raddr;
    logic [31:0]    vox_rdata;

    assign {h_cmd_bits, h_act, h_pixel, h_xs, h_ys, h_pos, h_off, h_vaddr} = i_entry;
    assign h_cmd = sasa_pkg::t_cmd'(h_cmd_bits);

    always_comb begin
        // Inside the shifted window the source pixel lies a fixed offset back.
        in_region = (r_r >= r_ys) && (32'(r_r) < HEIGHT - 1)
                 && (r_c >= r_xs) && (32'(r_c) < WIDTH - 1);
        img_raddr = in_region ? r_pos - r_off : r_pos;

        sum     = {1'b0, vox_rdata} + 33'(img_rdata);
        sat_sum = sum[32] ? '1 : sum[31:0];

        n_state    = r_state;
        n_r        = r_r;
        n_c        = r_c;
        n_pos      = r_pos;
        n_off      = r_off;
        n_xs       = r_xs;
        n_ys       = r_ys;
        n_vaddr    = r_vaddr;
        n_wr_vld   = 1'b0;
        n_wr_addr  = r_vaddr;
        n_clr      = r_clr;
        n_out_vld  = 1'b0;
        n_voxel    = r_voxel;
        n_done_cmd = r_done_cmd;

        o_pop     = 1'b0;
        img_we    = 1'b0;
        img_re    = 1'b0;
        vox_re    = 1'b0;
        vox_raddr = r_vaddr;

        case (r_state)
            sasa_pkg::B_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == VW'(VOX_WORDS - 1)) begin
                    n_state = sasa_pkg::B_IDLE;
                end
            end
            sasa_pkg::B_IDLE: begin
                if (!i_empty) begin
                    o_pop      = 1'b1;
                    n_done_cmd = h_cmd;
                    n_voxel    = '0;
                    case (h_cmd)
                        sasa_pkg::CMD_LOAD: begin
                            img_we    = h_act;
                            n_out_vld = 1'b1;
                        end
                        sasa_pkg::CMD_ACC: begin
                            if (h_act) begin
                                n_state = sasa_pkg::B_ACC;
                                n_r     = '0;
                                n_c     = '0;
                                n_pos   = '0;
                                n_off   = h_off;
                                n_vaddr = h_vaddr;
                                n_xs    = h_xs;
                                n_ys    = h_ys;
                            end else begin
                                n_out_vld = 1'b1;
                            end
                        end
                        sasa_pkg::CMD_READ: begin
                            if (h_act) begin
                                vox_re    = 1'b1;
                                vox_raddr = h_vaddr;
                                n_state   = sasa_pkg::B_READ;
                            end else begin
                                n_out_vld = 1'b1;
                            end
                        end
                        default: begin
                            n_out_vld = 1'b1;
                        end
                    endcase
                end
            end
            sasa_pkg::B_ACC: begin
                // Issue both reads now; the sum is written back next cycle.
                img_re    = 1'b1;
                vox_re    = 1'b1;
                n_wr_vld  = 1'b1;
                n_wr_addr = r_vaddr;
                n_vaddr   = r_vaddr + 1'b1;
                n_pos     = r_pos + 1'b1;
                if (r_c == XW'(WIDTH - 1)) begin
                    n_c = '0;
                    n_r = r_r + 1'b1;
                end else begin
                    n_c = r_c + 1'b1;
                end
                if (r_pos == PW'(PLANE - 1)) begin
                    n_state = sasa_pkg::B_DRAIN;
                end
            end
            sasa_pkg::B_DRAIN: begin
                n_out_vld = 1'b1;
                n_state   = sasa_pkg::B_IDLE;
            end
            sasa_pkg::B_READ: begin
                n_voxel   = vox_rdata;
                n_out_vld = 1'b1;
                n_state   = sasa_pkg::B_IDLE;
            end
            default: begin
                n_state = sasa_pkg::B_IDLE;
            end
        endcase

        if (r_state == sasa_pkg::B_CLEAR) begin
            vox_we    = 1'b1;
            vox_waddr = r_clr;
            vox_wdata = '0;
        end else begin
            vox_we    = r_wr_vld;
            vox_waddr = r_wr_addr;
            vox_wdata = sat_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sasa_pkg::B_CLEAR;
            r_clr     <= '0;
            r_wr_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_wr_vld  <= n_wr_vld;
            r_out_vld <= n_out_vld;
        end
        r_r        <= n_r;
        r_c        <= n_c;
        r_pos      <= n_pos;
        r_off      <= n_off;
        r_xs       <= n_xs;
        r_ys       <= n_ys;
        r_vaddr    <= n_vaddr;
        r_wr_addr  <= n_wr_addr;
        r_voxel    <= n_voxel;
        r_done_cmd <= n_done_cmd;
    end

    sasa_ram #(
        .DATA_W    (8),
        .ADDR_W    (PW),
        .NUM_WORDS (longint'(PLANE))
    ) u_image_ram (
        .i_clk   (i_clk),
        .i_we    (img_we),
        .i_waddr (h_pos),
        .i_wdata (h_pixel),
        .i_re    (img_re),
        .i_raddr (img_raddr),
        .o_rdata (img_rdata)
    );

    sasa_ram #(
        .DATA_W    (32),
        .ADDR_W    (VW),
        .NUM_WORDS (VOX_WORDS)
    ) u_voxel_ram (
        .i_clk   (i_clk),
        .i_we    (vox_we),
        .i_waddr (vox_waddr),
        .i_wdata (vox_wdata),
        .i_re    (vox_re),
        .i_raddr (vox_raddr),
        .o_rdata (vox_rdata)
    );

    assign o_clearing     = r_state == sasa_pkg::B_CLEAR;
    assign o_done         = r_out_vld;
    assign o_voxel_value  = r_voxel;
    assign o_done_command = r_done_cmd;

    // A voxel read must never target the word being written back this cycle.
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (vox_we && vox_re) |-> (vox_waddr != vox_raddr))
        else $error("voxel read collides with write-back");

    // The drain cycle always carries the last write-back of an accumulate.
    a_drain_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sasa_pkg::B_DRAIN) |-> r_wr_vld)
        else $error("drain without pending write-back");

    // No transaction leaves the queue while the clearing pass runs.
    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sasa_pkg::B_CLEAR) |-> !o_pop)
        else $error("pop during clearing pass");

    // The read state is followed by a valid result tagged as a read.
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sasa_pkg::B_READ) |=> (r_out_vld && r_done_cmd == sasa_pkg::CMD_READ))
        else $error("read result missing");

endmodule

`default_nettype wire

[hw/rtl/shift_add_slice_accumulator.sv]
// Shift-and-add slice accumulator. Each accepted command passes through a two-entry queue
// to the back end. The back end performs a load in its idle state and a read through its
// read state. It performs an accumulate through its accumulate and drain states, at one voxel
// read-modify-write per cycle. The queue keeps accepting while the back end is busy, until full.
// Reset is synchronous, active low; afterwards busy stays high for a clearing pass over all
// DEPTH*WIDTH*HEIGHT voxel words (65536 at default sizes). Results cannot be stalled.
`default_nettype none

module shift_add_slice_accumulator #(
    parameter int WIDTH  = sasa_pkg::WIDTH_DEF,
    parameter int HEIGHT = sasa_pkg::HEIGHT_DEF,
    parameter int DEPTH  = sasa_pkg::DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        i_command,
    input  wire logic [5:0]        i_row,
    input  wire logic [5:0]        i_col,
    input  wire logic [3:0]        i_slice,
    input  wire logic [7:0]        i_pixel,
    input  wire logic signed [7:0] i_shift_x,
    input  wire logic signed [7:0] i_shift_y,
    output logic                   o_done,
    output logic [31:0]            o_voxel_value,
    output logic [1:0]             o_done_command
);

    localparam int              PLANE     = WIDTH * HEIGHT;
    localparam longint unsigned VOX_WORDS = longint'(DEPTH) * longint'(PLANE);
    localparam int              XW        = $clog2(WIDTH);
    localparam int              YW        = $clog2(HEIGHT);
    localparam int              PW        = $clog2(PLANE);
    localparam int              VW        = $clog2(VOX_WORDS);
    localparam int              ENTRY_W   = 2 + 1 + 8 + XW + YW + PW + PW + VW;

    logic               push;
    logic [ENTRY_W-1:0] front_entry;
    logic [ENTRY_W-1:0] head_entry;
    logic               q_empty;
    logic               q_full;
    logic               pop;
    logic               clearing;

    assign busy = clearing || q_full;

    sasa_front #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT),
        .DEPTH  (DEPTH)
    ) u_front (
        .i_accept  (start && !busy),
        .i_command (i_command),
        .i_row     (i_row),
        .i_col     (i_col),
        .i_slice   (i_slice),
        .i_pixel   (i_pixel),
        .i_shift_x (i_shift_x),
        .i_shift_y (i_shift_y),
        .o_push    (push),
        .o_entry   (front_entry)
    );

    sasa_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_entry),
        .i_pop   (pop),
        .o_data  (head_entry),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    sasa_back #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT),
        .DEPTH  (DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_entry        (head_entry),
        .i_empty        (q_empty),
        .o_pop          (pop),
        .o_clearing     (clearing),
        .o_done         (o_done),
        .o_voxel_value  (o_voxel_value),
        .o_done_command (o_done_command)
    );

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for the shift-and-add slice accumulator: an image load, a directed
// table, then random transactions, checked against an in-bench model of image and volume.
// Depends on hw/rtl/sasa_pkg.sv and hw/rtl/shift_add_slice_accumulator.sv.
`timescale 1ns / 100ps

module tb_top;

    localparam int IMG_W         = sasa_pkg::WIDTH_DEF;
    localparam int IMG_H         = sasa_pkg::HEIGHT_DEF;
    localparam int N_SLICE       = sasa_pkg::DEPTH_DEF;
    localparam int PLANE         = IMG_W * IMG_H;
    localparam int RANDOM_ITEMS  = 140;
    localparam int CALM_TAIL     = 30;
    localparam int SETTLE_CYCLES = 16;
    localparam int N_DIRECTED    = 25;

    typedef struct packed {
        sasa_pkg::t_cmd cmd;
        logic [5:0]     row;
        logic [5:0]     col;
        logic [3:0]     slice;
        logic [7:0]     pixel;
        logic [7:0]     shift_x;
        logic [7:0]     shift_y;
        logic           pinned;
        logic [31:0]    pin_value;
    } t_voxel_cmd;

    typedef struct {
        logic [31:0]    value;
        sasa_pkg::t_cmd cmd;
    } t_voxel_result;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        start          = 1'b0;
    logic [1:0]  i_command      = sasa_pkg::CMD_LOAD;
    logic [5:0]  i_row          = '0;
    logic [5:0]  i_col          = '0;
    logic [3:0]  i_slice        = '0;
    logic [7:0]  i_pixel        = '0;
    logic signed [7:0] i_shift_x = '0;
    logic signed [7:0] i_shift_y = '0;
    logic        busy;
    logic        o_done;
    logic [31:0] o_voxel_value;
    logic [1:0]  o_done_command;

    // A directed row may carry its expected voxel value; it travels with the transaction.
    logic        pin_en    = 1'b0;
    logic [31:0] pin_value = '0;

    logic [7:0]  image_model  [PLANE];
    logic [31:0] volume_model [N_SLICE * PLANE];
    t_voxel_result pending_results [$];

    int err_count = 0;
    int n_loads   = 0;
    int n_accums  = 0;
    int n_reads   = 0;
    int n_other   = 0;
    int n_results = 0;

    // Extremes of every field, both shift clamps, the unknown command code and
    // repeated accumulation into one slice.
    t_voxel_cmd directed_plan [N_DIRECTED] = '{
        '{sasa_pkg::CMD_READ, 6'd0,  6'd0,  4'd0,  8'd0,   8'd0,  8'd0,  1'b1, 32'd0},
        '{sasa_pkg::CMD_READ, 6'd63, 6'd63, 4'd15, 8'd0,   8'd0,  8'd0,  1'b1, 32'd0},
        '{sasa_pkg::CMD_READ, 6'd0,  6'd63, 4'd7,  8'd0,   8'd0,  8'd0,  1'b1, 32'd0},
        '{sasa_pkg::CMD_NONE, 6'd63, 6'd63, 4'd15, 8'd255, 8'hFF, 8'hFF, 1'b1, 32'd0},
        '{sasa_pkg::CMD_NONE, 6'd0,  6'd0,  4'd0,  8'd0,   8'd0,  8'd0,  1'b1, 32'd0},
        '{sasa_pkg::CMD_LOAD, 6'd0,  6'd0,  4'd0,  8'd255, 8'd0,  8'd0,  1'b0, 32'd0},
        '{sasa_pkg::CMD_LOAD, 6'd63, 6'd63, 4'd0,  8'd0,   8'd0,  8'd0,  1'b0, 32'd0},
        '{sasa_pkg::CMD_ACC,  6'd0,  6'd0,  4'd0,  8'd0,   8'd0,  8'd0,  1'b0, 32'd0},
        '{sasa_pkg::CMD_READ, 6'd0,  6'd0,  4'd0,  8'd0,   8'd0,  8'd0,  1'b0, 32'd0},
        '{sasa_pkg::CMD_READ, 6'd63, 6'd63, 4'd0,  8'd0,   8'd0,  8'd0,  1'b0, 32'd0},
        '{sasa_pkg::CMD_ACC,  6'd0,  6'd0,  4'd15, 8'd0,   8'h7F, 8'h7F, 1'b0, 32'd0},
        '{sasa_pkg::CMD_READ, 6'd62, 6'd62, 4'd15, 8'd0,   8'd0,  8'd0,  1'b0, 32'd0},
        '{sasa_pkg::CMD_ACC,  6'd0,  6'd0,  4'd1,  8'd0,   8'h80, 8'h80, 1'b0, 32'd0},
        '{sasa_pkg::CMD_READ, 6'd31, 6'd17, 4'd1,  8'd0,   8'd0,  8'd0,  1'b0, 32'd0},
        '{sasa_pkg::CMD_ACC,  6'd0,  6'd0,  4'd2,  8'd0,   8'd63, 8'd0,  1'b0, 32'd0},
        '{sasa_pkg::CMD_ACC,  6'd0,  6'd0,  4'd2,  8'd0,   8'd64, 8'hFF, 1'b0, 32'd0},
        '{sasa_pkg::CMD_READ, 6'd40, 6'd63, 4'd2,  8'd0,   8'd0,  8'd0,  1'b0, 32'd0},
        '{sasa_pkg::CMD_ACC,  6'd0,  6'd0,  4'd3,  8'd0,   8'd5,  8'd9,  1'b0, 32'd0},
        '{sasa_pkg::CMD_READ, 6'd9,  6'd5,  4'd3,  8'd0,   8'd0,  8'd0,  1'b0, 32'd0},
        '{sasa_pkg::CMD_READ, 6'd62, 6'd62, 4'd3,  8'd0,   8'd0,  8'd0,  1'b0, 32'd0},
        '{sasa_pkg::CMD_READ, 6'd8,  6'd4,  4'd3,  8'd0,   8'd0,  8'd0,  1'b0, 32'd0},
        '{sasa_pkg::CMD_READ, 6'd63, 6'd0,  4'd3,  8'd0,   8'd0,  8'd0,  1'b0, 32'd0},
        '{sasa_pkg::CMD_ACC,  6'd0,  6'd0,  4'd0,  8'd0,   8'd62, 8'd62, 1'b0, 32'd0},
        '{sasa_pkg::CMD_READ, 6'd62, 6'd62, 4'd0,  8'd0,   8'd0,  8'd0,  1'b0, 32'd0},
        '{sasa_pkg::CMD_READ, 6'd63, 6'd63, 4'd15, 8'd0,   8'd0,  8'd0,  1'b0, 32'd0}
    };

    shift_add_slice_accumulator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_slice        (i_slice),
        .i_pixel        (i_pixel),
        .i_shift_x      (i_shift_x),
        .i_shift_y      (i_shift_y),
        .o_done         (o_done),
        .o_voxel_value  (o_voxel_value),
        .o_done_command (o_done_command)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #40ms;
        $display("[shift_add_slice_accumulator] ERROR");
        $finish;
    end

    function automatic int clamp_shift_to(logic [7:0] s, int size);
        int v;
        v = $signed(s);
        if (v < 0) begin
            return 0;
        end
        if (v > size - 1) begin
            return size - 1;
        end
        return v;
    endfunction

    // Inside the shifted window each voxel takes the displaced pixel; on the
    // last row and column and above or left of the shift it takes its own pixel.
    function automatic void add_shifted_plane(int slc, int xs, int ys);
        int sr;
        int sc;
        int idx;
        logic [32:0] sum;
        for (int r = 0; r < IMG_H; r++) begin
            for (int c = 0; c < IMG_W; c++) begin
                sr = r;
                sc = c;
                if (r >= ys && r < IMG_H - 1 && c >= xs && c < IMG_W - 1) begin
                    sr = r - ys;
                    sc = c - xs;
                end
                idx = slc * PLANE + r * IMG_W + c;
                sum = {1'b0, volume_model[idx]} + 33'(image_model[sr * IMG_W + sc]);
                volume_model[idx] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
        end
    endfunction

    function automatic logic [31:0] apply_voxel_command(sasa_pkg::t_cmd cmd, int row, int col,
                                                        int slc, logic [7:0] pixel,
                                                        logic [7:0] sx, logic [7:0] sy);
        logic pos_ok;
        pos_ok = row < IMG_H && col < IMG_W;
        case (cmd)
            sasa_pkg::CMD_LOAD: begin
                if (pos_ok) begin
                    image_model[row * IMG_W + col] = pixel;
                end
            end
            sasa_pkg::CMD_ACC: begin
                if (slc < N_SLICE) begin
                    add_shifted_plane(slc, clamp_shift_to(sx, IMG_W), clamp_shift_to(sy, IMG_H));
                end
            end
            sasa_pkg::CMD_READ: begin
                if (pos_ok && slc < N_SLICE) begin
                    return volume_model[slc * PLANE + row * IMG_W + col];
                end
            end
            default: ;
        endcase
        return 32'd0;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("%0t: mismatch on %s: expected 0x%08h, got 0x%08h", $time, what, want, got);
        err_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_voxel_result want;
        logic [31:0]   value;
        if (i_rst_n) begin
            if (o_done) begin
                n_results++;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", 32'd0, o_voxel_value);
                end else begin
                    want = pending_results.pop_front();
                    if (o_voxel_value !== want.value) begin
                        report_mismatch("voxel_value", want.value, o_voxel_value);
                    end
                    if (o_done_command !== want.cmd) begin
                        report_mismatch("done_command", 32'(want.cmd), 32'(o_done_command));
                    end
                end
            end
            if (start && !busy) begin
                value = apply_voxel_command(sasa_pkg::t_cmd'(i_command), int'(i_row),
                                            int'(i_col), int'(i_slice),
                                            i_pixel, i_shift_x, i_shift_y);
                if (pin_en) begin
                    value = pin_value;
                end
                pending_results.push_back('{value, sasa_pkg::t_cmd'(i_command)});
                case (sasa_pkg::t_cmd'(i_command))
                    sasa_pkg::CMD_LOAD: n_loads++;
                    sasa_pkg::CMD_ACC:  n_accums++;
                    sasa_pkg::CMD_READ: n_reads++;
                    default:            n_other++;
                endcase
            end
        end
    end

    // Called just after a falling edge; returns at the falling edge after acceptance.
    task automatic issue(t_voxel_cmd c);
        i_command <= c.cmd;
        i_row     <= c.row;
        i_col     <= c.col;
        i_slice   <= c.slice;
        i_pixel   <= c.pixel;
        i_shift_x <= c.shift_x;
        i_shift_y <= c.shift_y;
        pin_en    <= c.pinned;
        pin_value <= c.pin_value;
        start     <= 1'b1;
        while (busy) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic idle(int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    initial begin
        t_voxel_cmd c;
        int pick;
        for (int k = 0; k < N_SLICE * PLANE; k++) begin
            volume_model[k] = 32'd0;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Every pixel is written before the first accumulate reads the image.
        for (int p = 0; p < PLANE; p++) begin
            c = '{sasa_pkg::CMD_LOAD, 6'(p / IMG_W), 6'(p % IMG_W), 4'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 32'd0};
            if (p == 0) begin
                c.pixel = 8'd0;
            end else if (p == PLANE - 1) begin
                c.pixel = 8'd255;
            end
            issue(c);
        end

        foreach (directed_plan[k]) begin
            issue(directed_plan[k]);
            if ($urandom_range(0, 3) == 0) begin
                idle($urandom_range(1, 14));
            end
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            c = '{sasa_pkg::CMD_NONE, 6'($urandom), 6'($urandom), 4'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 32'd0};
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                c.cmd = sasa_pkg::CMD_LOAD;
            end else if (pick < 78) begin
                c.cmd = sasa_pkg::CMD_READ;
            end else if (pick < 90) begin
                c.cmd = sasa_pkg::CMD_ACC;
                // Half of the shifts stay inside the image so the window is not trivial.
                if ($urandom_range(0, 1) == 1) begin
                    c.shift_x = 8'($urandom_range(0, IMG_W - 1));
                    c.shift_y = 8'($urandom_range(0, IMG_H - 1));
                end
            end
            issue(c);
            if (n < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
                idle($urandom_range(1, 14));
            end
        end
        start <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d loads, %0d accumulates, %0d reads and %0d unknown commands;",
                 n_loads, n_accums, n_reads, n_other);
        $display("%0d results checked, %0d mismatches.", n_results, err_count);
        if (err_count == 0) begin
            $display("[shift_add_slice_accumulator] OK");
        end else begin
            $display("[shift_add_slice_accumulator] ERROR");
        end
        $finish;
    end

endmodule
